// ----- rtl/core/soca_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// soca_pkg
// Shared types, constants and helpers of the second-order attitude filter.
// ----------------------------------------------------------------------------
package soca_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int FRACTION_BITS = 16;

    localparam int CNT_W  = $clog2(CORDIC_STEPS + 1);
    localparam int CRD_W  = 35;

    localparam int IDX_W  = 3;
    localparam int DATA_W = 32;

    localparam logic [IDX_W-1:0] REG_GAIN_X  = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_Y  = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_Z  = 3'd2;
    localparam logic [IDX_W-1:0] REG_LIMIT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_MIN_ACC = 3'd4;

    localparam logic CMD_INIT   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_LOOP,
        ST_DONE
    } t_top_state;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_MUL_E,
        LS_MUL_P,
        LS_MUL_I,
        LS_INTEG,
        LS_MUL_S,
        LS_ANGLE,
        LS_DONE
    } t_lane_state;

    typedef struct packed {
        logic start;
        logic init;
    } t_lane_ctl;

    // saturate to signed 32 bit
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // arctangent table, Q2.30, truncated
    function automatic logic signed [CRD_W-1:0] atan_q30(input logic [CNT_W-1:0] i);
        logic signed [CRD_W-1:0] r;
        case (i)
            5'd0:    r = 35'sd843314856;
            5'd1:    r = 35'sd497837829;
            5'd2:    r = 35'sd263043836;
            5'd3:    r = 35'sd133525158;
            5'd4:    r = 35'sd67021686;
            5'd5:    r = 35'sd33543515;
            5'd6:    r = 35'sd16775850;
            5'd7:    r = 35'sd8388437;
            5'd8:    r = 35'sd4194282;
            5'd9:    r = 35'sd2097149;
            5'd10:   r = 35'sd1048575;
            5'd11:   r = 35'sd524287;
            5'd12:   r = 35'sd262143;
            5'd13:   r = 35'sd131071;
            5'd14:   r = 35'sd65535;
            5'd15:   r = 35'sd32767;
            5'd16:   r = 35'sd16383;
            5'd17:   r = 35'sd8191;
            5'd18:   r = 35'sd4095;
            5'd19:   r = 35'sd2047;
            5'd20:   r = 35'sd1023;
            5'd21:   r = 35'sd511;
            5'd22:   r = 35'sd255;
            5'd23:   r = 35'sd127;
            5'd24:   r = 35'sd63;
            5'd25:   r = 35'sd31;
            5'd26:   r = 35'sd15;
            5'd27:   r = 35'sd7;
            5'd28:   r = 35'sd3;
            5'd29:   r = 35'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/soca_ifs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// soca channel interfaces
// Sample request, result request and register write channels.
// ----------------------------------------------------------------------------
interface soca_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic        [15:0] step_time;
    modport source (output valid, command, rate_x, rate_y, rate_z, acc_x, acc_y, acc_z,
                    step_time, input ready);
    modport sink   (input valid, command, rate_x, rate_y, rate_z, acc_x, acc_y, acc_z,
                    step_time, output ready);
endinterface

interface soca_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] angle_out_x;
    logic signed [31:0] angle_out_y;
    logic signed [31:0] angle_out_z;
    modport source (output valid, angle_out_x, angle_out_y, angle_out_z, input ready);
    modport sink   (input valid, angle_out_x, angle_out_y, angle_out_z, output ready);
endinterface

interface soca_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/soca_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// soca_cordic
// Vectoring CORDIC, one rotation per cycle, gives atan2(num, den) for den >= 0.
// ----------------------------------------------------------------------------
module soca_cordic
    import soca_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_angle
);

    logic                    r_busy;
    logic                    r_done;
    logic                    r_zero;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [CRD_W-1:0] r_x, r_y, r_z;
    logic signed [CRD_W-1:0] sx, sy, rnd;

    assign sx = r_x >>> r_cnt;
    assign sy = r_y >>> r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CRD_W'(i_den);
            r_y    <= CRD_W'(i_num);
            r_z    <= '0;
            r_zero <= (i_num == '0) && (i_den == '0);
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + atan_q30(r_cnt);
            end else begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - atan_q30(r_cnt);
            end
        end
    end

    // round half up to the output fraction
    assign rnd     = (r_z + (CRD_W'(1) <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
    assign o_angle = r_zero ? '0 : rnd[31:0];
    assign o_done  = r_done;

endmodule
`default_nettype wire

// ----- rtl/core/soca_axis.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// soca_axis
// One axis lane: second-order loop state and its multiply sequence.
// ----------------------------------------------------------------------------
module soca_axis
    import soca_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_lane_ctl          i_ctl,
    input  wire logic signed [31:0] i_ref,
    input  wire logic signed [31:0] i_rate,
    input  wire logic signed [31:0] i_acc,
    input  wire logic        [15:0] i_gain,
    input  wire logic        [15:0] i_dt,
    output logic                    o_done,
    output logic signed [31:0]      o_angle
);

    t_lane_state        r_state, n_state;
    logic signed [31:0] r_est, r_integ;
    logic signed [32:0] r_e;
    logic signed [49:0] r_ek;
    logic signed [31:0] r_prop;
    logic signed [48:0] r_pk;
    logic signed [48:0] r_idt;
    logic signed [50:0] r_sdt;
    logic signed [16:0] k_s, dt_s;
    logic signed [33:0] sum;

    assign k_s  = $signed({1'b0, i_gain});
    assign dt_s = $signed({1'b0, i_dt});
    assign sum  = 34'(r_integ) + 34'(r_prop) + 34'(i_rate);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LS_IDLE:  if (i_ctl.start) n_state = i_ctl.init ? LS_DONE : LS_MUL_E;
            LS_MUL_E: n_state = LS_MUL_P;
            LS_MUL_P: n_state = LS_MUL_I;
            LS_MUL_I: n_state = LS_INTEG;
            LS_INTEG: n_state = LS_MUL_S;
            LS_MUL_S: n_state = LS_ANGLE;
            LS_ANGLE: n_state = LS_DONE;
            LS_DONE:  n_state = LS_IDLE;
            default:  n_state = LS_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == LS_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= LS_IDLE;
        else
            r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est   <= '0;
            r_integ <= '0;
        end else begin
            case (r_state)
                LS_IDLE: begin
                    if (i_ctl.start && i_ctl.init) begin
                        r_est   <= i_acc;
                        r_integ <= sat32(-64'(i_rate));
                    end
                end
                LS_INTEG: r_integ <= sat32(64'(r_integ) + 64'(sat32(64'(r_idt >>> 16))));
                LS_ANGLE: r_est   <= sat32(64'(r_est) + 64'(r_sdt >>> 16));
                default: ;
            endcase
        end
    end

    // payload pipeline, one multiplier product registered per step
    always_ff @(posedge i_clk) begin
        case (r_state)
            LS_IDLE:  r_e <= 33'(i_ref) - 33'(r_est);
            LS_MUL_E: r_ek <= 50'(r_e) * 50'(k_s);
            LS_MUL_P: begin
                r_prop <= sat32(64'(r_ek >>> 7));
                r_pk   <= 49'(sat32(64'(r_ek >>> 8))) * 49'(k_s);
            end
            LS_MUL_I: r_idt <= 49'(sat32(64'(r_pk >>> 8))) * 49'(dt_s);
            LS_MUL_S: r_sdt <= 51'(sum) * 51'(dt_s);
            default: ;
        endcase
    end

    assign o_angle = r_est;

endmodule
`default_nettype wire

// ----- rtl/core/second_order_complementary_attitude.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// second_order_complementary_attitude
// Three-axis second-order complementary attitude filter, Q16.16.
// ----------------------------------------------------------------------------
// usage
// - i_in carries one sample request: command, gyro rates, accel vector and
//   step time; command init loads the angles from accel and the integrators
//   from minus the rates, command update runs one filter step
// - o_out carries one result request per sample: the three angles after it
// - i_cfg writes gains, angle limit and minimum vertical accel; write only
//   while no sample is in flight, always ready
// - a sample runs through the atan2 CORDIC (one rotation per cycle, started
//   at the accept edge), then the per-axis loop sequence, then the handoff
//   into the output register; the next sample is taken only after the
//   result has moved into the output register
// - the x and y lanes each own a CORDIC, all three lanes run in parallel
// - reset clears angles and integrators and loads the register defaults
// - a stalled receiver holds the result; one more sample may then be
//   processed and waits in the lanes until the output register frees up
// ----------------------------------------------------------------------------
module second_order_complementary_attitude
    import soca_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    soca_in_if.sink    i_in,
    soca_out_if.source o_out,
    soca_cfg_if.sink   i_cfg
);

    // configuration registers
    logic [15:0] r_gain_x, r_gain_y, r_gain_z;
    logic [30:0] r_limit, r_min_acc;

    // latched sample
    logic               r_cmd;
    logic signed [31:0] r_rate_x, r_rate_y, r_rate_z;
    logic signed [31:0] r_acc_x, r_acc_y, r_acc_z;
    logic        [15:0] r_dt;

    t_top_state r_state, n_state;

    logic               r_out_valid;
    logic signed [31:0] r_out_x, r_out_y, r_out_z;

    logic               in_req, crd_start, crd_done_x, crd_done_y, crd_done;
    logic signed [31:0] crd_x, crd_y;
    t_lane_ctl          lane_ctl;
    logic [2:0]         lane_done;
    logic signed [31:0] est_x, est_y, est_z, ref_x, ref_y;
    logic               low_acc, own_x, own_y, out_load;

    assign in_req = i_in.valid && i_in.ready;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_x  <= 16'd256;
            r_gain_y  <= 16'd256;
            r_gain_z  <= 16'd256;
            r_limit   <= 31'd1966080;
            r_min_acc <= 31'd32768;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_GAIN_X:  r_gain_x  <= i_cfg.data[15:0];
                REG_GAIN_Y:  r_gain_y  <= i_cfg.data[15:0];
                REG_GAIN_Z:  r_gain_z  <= i_cfg.data[15:0];
                REG_LIMIT:   r_limit   <= i_cfg.data[30:0];
                REG_MIN_ACC: r_min_acc <= i_cfg.data[30:0];
                default: ;
            endcase
        end
    end

    // sample capture
    always_ff @(posedge i_clk) begin
        if (in_req) begin
            r_cmd    <= i_in.command;
            r_rate_x <= i_in.rate_x;
            r_rate_y <= i_in.rate_y;
            r_rate_z <= i_in.rate_z;
            r_acc_x  <= i_in.acc_x;
            r_acc_y  <= i_in.acc_y;
            r_acc_z  <= i_in.acc_z;
            r_dt     <= i_in.step_time;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_req) n_state = ST_CORDIC;
            ST_CORDIC: if (crd_done) n_state = ST_LOOP;
            ST_LOOP:   if (&lane_done) n_state = ST_DONE;
            ST_DONE:   if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready     = (r_state == ST_IDLE);
        crd_start      = in_req;
        lane_ctl.start = (r_state == ST_CORDIC) && crd_done;
        lane_ctl.init  = (r_cmd == CMD_INIT);
        out_load       = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_IDLE;
        else
            r_state <= n_state;
    end

    // accel angles for x and y, operands taken straight from the request
    soca_cordic u_cordic_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (crd_start),
        .i_num   (i_in.acc_x),
        .i_den   (i_in.acc_z),
        .o_done  (crd_done_x),
        .o_angle (crd_x)
    );

    soca_cordic u_cordic_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (crd_start),
        .i_num   (i_in.acc_y),
        .i_den   (i_in.acc_z),
        .o_done  (crd_done_y),
        .o_angle (crd_y)
    );

    assign crd_done = crd_done_x && crd_done_y;

    // reference choice: fall back to own estimate on low vertical accel or large angle
    assign low_acc = 33'(r_acc_z) < $signed({2'b00, r_min_acc});
    assign own_x   = low_acc || (33'(est_x) > $signed({2'b00, r_limit}))
                             || (33'(est_x) < -$signed({2'b00, r_limit}));
    assign own_y   = low_acc || (33'(est_y) > $signed({2'b00, r_limit}))
                             || (33'(est_y) < -$signed({2'b00, r_limit}));
    assign ref_x   = own_x ? est_x : crd_x;
    assign ref_y   = own_y ? est_y : crd_y;

    // axis lanes
    soca_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_ref   (ref_x),
        .i_rate  (r_rate_x),
        .i_acc   (r_acc_x),
        .i_gain  (r_gain_x),
        .i_dt    (r_dt),
        .o_done  (lane_done[0]),
        .o_angle (est_x)
    );

    soca_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_ref   (ref_y),
        .i_rate  (r_rate_y),
        .i_acc   (r_acc_y),
        .i_gain  (r_gain_y),
        .i_dt    (r_dt),
        .o_done  (lane_done[1]),
        .o_angle (est_y)
    );

    // z uses its own estimate as reference
    soca_axis u_axis_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_ref   (est_z),
        .i_rate  (r_rate_z),
        .i_acc   (r_acc_z),
        .i_gain  (r_gain_z),
        .i_dt    (r_dt),
        .o_done  (lane_done[2]),
        .o_angle (est_z)
    );

    // merge lanes into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x <= est_x;
            r_out_y <= est_y;
            r_out_z <= est_z;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.angle_out_x = r_out_x;
    assign o_out.angle_out_y = r_out_y;
    assign o_out.angle_out_z = r_out_z;

endmodule
`default_nettype wire

// ----- tb/tb_soca_ifs.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb soca channel interfaces
// The testbench shares the channel interfaces of the design.
// ----------------------------------------------------------------------------

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives init and update samples plus register writes into the attitude
// filter under several idle patterns and checks every angle result against
// a bit-exact fixed-point prediction of the filter.
// ----------------------------------------------------------------------------
module tb_top;
    import soca_pkg::*;

    // one sample request
    typedef struct {
        logic               command;
        logic signed [31:0] rate [3];
        logic signed [31:0] acc [3];
        logic        [15:0] step_time;
    } t_sample;

    // one result request
    typedef struct {
        logic signed [31:0] angle [3];
    } t_angles;

    int error_count = 0;

    task automatic report(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // attitude predictor plus store of expected angles
    class attitude_scoreboard;
        longint  gain [3];
        longint  angle_limit;
        longint  min_vert;
        longint  integ [3];
        longint  est [3];
        t_angles pending [$];

        function new();
            gain = '{256, 256, 256};
            angle_limit = 1966080;
            min_vert = 32768;
            integ = '{0, 0, 0};
            est = '{0, 0, 0};
        endfunction

        // >>> on longint is arithmetic, i.e. floor
        function longint clip(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint atan_tab(int i);
            longint t [16];
            t = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                  16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                  131071, 65535, 32767};
            return t[i];
        endfunction

        function longint vector_angle(longint num, longint den);
            longint x, y, z, nx;
            x = den;
            y = num;
            z = 0;
            if (num == 0 && den == 0) return 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (y >= 0) begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z += atan_tab(i);
                end else begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z -= atan_tab(i);
                end
                x = nx;
            end
            return (z + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
        endfunction

        function void loop_step(int a, longint target, longint rate, longint k, longint dt);
            longint e, p, i1, prop, sum;
            e    = target - est[a];
            p    = clip((e * k) >>> 8);
            i1   = clip((p * k) >>> 8);
            integ[a] = clip(integ[a] + clip((i1 * dt) >>> 16));
            prop = clip((e * k) >>> 7);
            sum  = integ[a] + prop + rate;
            est[a] = clip(est[a] + ((sum * dt) >>> 16));
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_GAIN_X:  gain[0] = data[15:0];
                REG_GAIN_Y:  gain[1] = data[15:0];
                REG_GAIN_Z:  gain[2] = data[15:0];
                REG_LIMIT:   angle_limit = data[30:0];
                REG_MIN_ACC: min_vert = data[30:0];
                default: ;
            endcase
        endfunction

        function void note_sample(t_sample s);
            longint  target [2];
            longint  az;
            t_angles r;
            az = s.acc[2];
            if (s.command == CMD_INIT) begin
                for (int a = 0; a < 3; a++) begin
                    est[a]   = s.acc[a];
                    integ[a] = clip(-longint'(s.rate[a]));
                end
            end else begin
                for (int a = 0; a < 2; a++) begin
                    if (az < min_vert || est[a] > angle_limit || est[a] < -angle_limit)
                        target[a] = est[a];
                    else
                        target[a] = vector_angle(s.acc[a], az);
                end
                loop_step(0, target[0], s.rate[0], gain[0], s.step_time);
                loop_step(1, target[1], s.rate[1], gain[1], s.step_time);
                loop_step(2, est[2], s.rate[2], gain[2], s.step_time);
            end
            for (int a = 0; a < 3; a++) r.angle[a] = est[a][31:0];
            pending.push_back(r);
        endfunction

        task check_result(logic signed [31:0] ax, logic signed [31:0] ay,
                          logic signed [31:0] az);
            t_angles w;
            if (pending.size() == 0) begin
                report("unexpected result", ax, 0);
                return;
            end
            w = pending.pop_front();
            if (ax !== w.angle[0]) report("angle_out_x", ax, w.angle[0]);
            if (ay !== w.angle[1]) report("angle_out_y", ay, w.angle[1]);
            if (az !== w.angle[2]) report("angle_out_z", az, w.angle[2]);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #2 i_clk = ~i_clk;

    soca_in_if  in_ch ();
    soca_out_if out_ch ();
    soca_cfg_if cfg_ch ();

    second_order_complementary_attitude uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    attitude_scoreboard angle_board = new();

    // idle percentages, changed per phase
    int send_idle = 0;
    int recv_stall = 0;
    longint cycle_count = 0;

    // result side: ready toggled at falling edges, checked at rising edges
    initial out_ch.ready = 1'b0;
    always @(negedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready)
            angle_board.check_result(out_ch.angle_out_x, out_ch.angle_out_y,
                                     out_ch.angle_out_z);
        if (cycle_count > 600000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // register write while the filter is idle
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        angle_board.write_reg(idx, data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // every request answered, then a little slack
    task automatic drain();
        while (angle_board.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // one sample request, gap before it at the sender's idle rate
    task automatic send(t_sample s);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.command   <= s.command;
        in_ch.rate_x    <= s.rate[0];
        in_ch.rate_y    <= s.rate[1];
        in_ch.rate_z    <= s.rate[2];
        in_ch.acc_x     <= s.acc[0];
        in_ch.acc_y     <= s.acc[1];
        in_ch.acc_z     <= s.acc[2];
        in_ch.step_time <= s.step_time;
        do @(posedge i_clk); while (!in_ch.ready);
        angle_board.note_sample(s);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_word();
        return $urandom();
    endfunction

    // realistic sample: small angles, gravity mostly on z, occasional wild values
    function automatic t_sample rand_sample(int init_pct);
        t_sample s;
        s.command = ($urandom_range(99) < init_pct) ? CMD_INIT : CMD_UPDATE;
        for (int a = 0; a < 3; a++) begin
            if ($urandom_range(9) == 0) begin
                s.rate[a] = rand_word();
                s.acc[a]  = rand_word();
            end else begin
                s.rate[a] = $signed($urandom_range(400000)) - 200000;
                s.acc[a]  = $signed($urandom_range(131072)) - 65536;
            end
        end
        if ($urandom_range(9) != 0) s.acc[2] = $urandom_range(131072);
        case ($urandom_range(9))
            0:       s.step_time = 16'hffff;
            1:       s.step_time = 16'h0000;
            2:       s.step_time = 16'($urandom());
            default: s.step_time = 16'($urandom_range(2000));
        endcase
        return s;
    endfunction

    function automatic t_sample make(logic cmd, longint r, longint ax, longint ay,
                                     longint az, logic [15:0] dt);
        t_sample s;
        s.command = cmd;
        s.rate = '{r[31:0], -r[31:0], r[31:0]};
        s.acc  = '{ax[31:0], ay[31:0], az[31:0]};
        s.step_time = dt;
        return s;
    endfunction

    initial begin
        in_ch.valid = 1'b0;
        in_ch.command = CMD_INIT;
        in_ch.rate_x = '0;
        in_ch.rate_y = '0;
        in_ch.rate_z = '0;
        in_ch.acc_x = '0;
        in_ch.acc_y = '0;
        in_ch.acc_z = '0;
        in_ch.step_time = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_GAIN_X;
        cfg_ch.data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, both commands, each fallback path
        send(make(CMD_UPDATE, 0, 0, 0, 0, 16'h1000));          // both operands zero
        send(make(CMD_INIT, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                  64'sd2147483647, 16'h0000));                  // negating most negative
        send(make(CMD_UPDATE, 64'sd2147483647, 100, 100, 65536, 16'hffff)); // estimate over limit
        send(make(CMD_INIT, 1000, 1000, -2000, 0, 16'h0000));
        send(make(CMD_UPDATE, 5000, 30000, -40000, 65536, 16'h0100));
        send(make(CMD_UPDATE, 5000, 30000, -40000, 1000, 16'h0100));   // low vertical accel
        send(make(CMD_UPDATE, -5000, -65536, 65536, 32768, 16'h0100)); // at min accel
        send(make(CMD_UPDATE, 0, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
                  16'hffff));
        send(make(CMD_UPDATE, 7, 1, 1, 1, 16'h0000));                  // zero step time
        send(make(CMD_UPDATE, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
                  -64'sd2147483648, 16'h8000));
        send(make(CMD_INIT, 0, 1966080, -1966080, 65536, 16'h0000));   // estimate at limit
        send(make(CMD_UPDATE, 0, 0, 0, 65536, 16'h0040));
        drain();

        // gain extremes and limit extremes
        write_reg(REG_GAIN_X, 32'h0000_ffff);
        write_reg(REG_GAIN_Y, 32'h0000_0000);
        write_reg(REG_GAIN_Z, 32'h0000_ffff);
        write_reg(REG_LIMIT, 32'h7fff_ffff);
        write_reg(REG_MIN_ACC, 32'h0000_0000);
        send(make(CMD_INIT, 300, 20000, -20000, 65536, 16'h0000));
        send(make(CMD_UPDATE, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                  0, 16'hffff));
        send(make(CMD_UPDATE, 1, -65536, 65536, 0, 16'h0400));
        drain();

        // random phases: settings x idle patterns
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 88; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 88; end
                default: begin send_idle = 24; recv_stall = 24; end
            endcase
            if (ph == 4) begin
                write_reg(REG_LIMIT, 32'h0000_0000);
                write_reg(REG_MIN_ACC, 32'h7fff_ffff);
            end else begin
                write_reg(REG_GAIN_X, $urandom_range(1024));
                write_reg(REG_GAIN_Y, $urandom_range(1024));
                write_reg(REG_GAIN_Z, (ph == 7) ? 32'h0000_ffff : $urandom_range(1024));
                write_reg(REG_LIMIT, $urandom_range(400000));
                write_reg(REG_MIN_ACC, (ph == 6) ? 32'h7fff_ffff : $urandom_range(40000));
            end
            for (int n = 0; n < 125; n++) begin
                send(rand_sample(n == 0 ? 100 : 5));
                // sender holds off until all results are back
                if (n == 60) while (angle_board.pending.size() != 0) @(negedge i_clk);
            end
            drain();
        end

        recv_stall = 0;
        drain();
        if (error_count == 0 && angle_board.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
